@@ design/pxy_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar XY to latitude/longitude package
// Shared widths, sideband types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package pxy_pkg;

	localparam int COORD_BITS    = 24;
	localparam int FRAC_BITS     = 16;
	localparam int CORDIC_STAGES = 20;
	localparam int CORDIC_GUARD  = 24;

	localparam int LAT_W  = 24;
	localparam int LON_W  = 25;
	localparam int CW     = COORD_BITS + CORDIC_GUARD + 3;
	localparam int ZW     = 42;
	localparam int SHW    = 5;
	localparam int PW     = 32;
	localparam int QW     = 33;
	localparam int MAGW   = 50;
	localparam int NW     = 59;

	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131497;
	localparam logic signed [63:0] DEG_PER_RAD_Q32 = 64'sd246083499208;

	typedef struct packed {
		logic north;
		logic x_zero;
		logic x_neg;
		logic u_neg;
	} cside_t;

	typedef struct packed {
		logic              north;
		logic              ovf;
		logic [LON_W-1:0]  lon;
	} dside_t;

	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [63:0] t;
		logic signed [63:0] head [8];
		head[0] = 64'sd193273528320;
		head[1] = 64'sd114096026022;
		head[2] = 64'sd60285206654;
		head[3] = 64'sd30601712202;
		head[4] = 64'sd15360239180;
		head[5] = 64'sd7687607525;
		head[6] = 64'sd3844741810;
		head[7] = 64'sd1922488225;
		if (i < 8) begin
			t = head[i];
		end else begin
			t = DEG_PER_RAD_Q32 >>> i;
			if (3 * i < 64) begin
				t = t - ((DEG_PER_RAD_Q32 >>> (3 * i)) / 3);
			end
		end
		return t[ZW-1:0];
	endfunction

endpackage

@@ design/pxy_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward the positive u axis, registered.
// ----------------------------------------------------------------------------
module pxy_cordic_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [pxy_pkg::SHW-1:0]          shift,
	input  logic signed [pxy_pkg::ZW-1:0]    atan,
	input  logic                             vld_in,
	input  logic signed [pxy_pkg::CW-1:0]    cu_in,
	input  logic signed [pxy_pkg::CW-1:0]    cv_in,
	input  logic signed [pxy_pkg::ZW-1:0]    z_in,
	input  pxy_pkg::cside_t                  side_in,
	output logic                             vld_q,
	output logic signed [pxy_pkg::CW-1:0]    cu_q,
	output logic signed [pxy_pkg::CW-1:0]    cv_q,
	output logic signed [pxy_pkg::ZW-1:0]    z_q,
	output pxy_pkg::cside_t                  side_q
);
	import pxy_pkg::*;

	logic signed [CW-1:0] su;
	logic signed [CW-1:0] sv;

	assign su = cu_in >>> shift;
	assign sv = cv_in >>> shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			if (!cv_in[CW-1]) begin
				cu_q <= cu_in + sv;
				cv_q <= cv_in - su;
				z_q  <= z_in + atan;
			end else begin
				cu_q <= cu_in - sv;
				cv_q <= cv_in + su;
				z_q  <= z_in - atan;
			end
		end
	end

endmodule

@@ design/pxy_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
module pxy_div_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [pxy_pkg::PW-1:0]       divisor,
	input  logic                         vld_in,
	input  logic [pxy_pkg::PW-1:0]       rem_in,
	input  logic [pxy_pkg::QW-1:0]       num_in,
	input  logic [pxy_pkg::QW-1:0]       quo_in,
	input  pxy_pkg::dside_t              side_in,
	output logic                         vld_q,
	output logic [pxy_pkg::PW-1:0]       rem_q,
	output logic [pxy_pkg::QW-1:0]       num_q,
	output logic [pxy_pkg::QW-1:0]       quo_q,
	output pxy_pkg::dside_t              side_q
);
	import pxy_pkg::*;

	logic [PW:0] trial;
	logic [PW:0] diff;

	assign trial = {rem_in, num_in[QW-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			num_q  <= {num_in[QW-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[PW-1:0];
				quo_q <= {quo_in[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[PW-1:0];
				quo_q <= {quo_in[QW-2:0], 1'b0};
			end
		end
	end

endmodule

@@ design/polar_xy_to_lat_lon.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar XY to latitude/longitude
// Inverse polar azimuthal equidistant projection over a CORDIC cell row and
// a divider cell row.
// One transaction is accepted per cycle; the whole pipeline stalls together
// while the output register holds an untaken result.
// Twenty CORDIC cells and thirty-three divider cells form the two cell rows.
// Reset clears all valid flags and sets pixels_per_circle to 1.
// ----------------------------------------------------------------------------
module polar_xy_to_lat_lon (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // x_offset[23:0], y_offset[47:24]
	input  logic        s_axis_tuser,   // north_hemisphere
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // latitude[23:0], longitude[48:24], zero
	output logic        m_axis_tuser    // beyond_range
);
	import pxy_pkg::*;

	localparam int NS = CORDIC_STAGES;
	localparam int RS = CORDIC_GUARD - FRAC_BITS;
	localparam logic signed [ZW-1:0] Z90 = ZW'(64'sd90 <<< 32);
	localparam logic signed [LON_W-1:0] LON180 = LON_W'(180 <<< FRAC_BITS);
	localparam logic [25:0] DIST180 = 26'(180 <<< FRAC_BITS);
	localparam logic signed [26:0] LAT90 = 27'(90 <<< FRAC_BITS);

	logic        en;
	logic [31:0] ppc_q;
	logic [PW-1:0] p_eff;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign p_eff = (ppc_q == '0) ? PW'(1) : ppc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppc_q <= 32'd1;
		end else if (cfg_wr_en) begin
			ppc_q <= cfg_wr_data;
		end
	end

	// Pre-rotation into the right half plane.
	logic signed [COORD_BITS-1:0] x_in;
	logic signed [COORD_BITS-1:0] y_in;
	logic signed [COORD_BITS:0]   u_in;
	logic signed [CW-1:0]         cu0;
	logic signed [CW-1:0]         cv0;

	assign x_in = s_axis_tdata[COORD_BITS-1:0];
	assign y_in = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign u_in = s_axis_tuser ? -{y_in[COORD_BITS-1], y_in} : {y_in[COORD_BITS-1], y_in};
	assign cu0  = {{(CW-COORD_BITS-1-CORDIC_GUARD){u_in[COORD_BITS]}}, u_in,
		{CORDIC_GUARD{1'b0}}};
	assign cv0  = {{(CW-COORD_BITS-CORDIC_GUARD){x_in[COORD_BITS-1]}}, x_in,
		{CORDIC_GUARD{1'b0}}};

	logic                 vld_c [NS+1];
	logic signed [CW-1:0] cu_c  [NS+1];
	logic signed [CW-1:0] cv_c  [NS+1];
	logic signed [ZW-1:0] z_c   [NS+1];
	cside_t               sd_c  [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (en) begin
			vld_c[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_c[0].north  <= s_axis_tuser;
			sd_c[0].x_zero <= (x_in == '0);
			sd_c[0].x_neg  <= x_in[COORD_BITS-1];
			sd_c[0].u_neg  <= u_in[COORD_BITS];
			if (!u_in[COORD_BITS]) begin
				cu_c[0] <= cu0;
				cv_c[0] <= cv0;
				z_c[0]  <= '0;
			end else if (!x_in[COORD_BITS-1]) begin
				cu_c[0] <= cv0;
				cv_c[0] <= -cu0;
				z_c[0]  <= Z90;
			end else begin
				cu_c[0] <= -cv0;
				cv_c[0] <= cu0;
				z_c[0]  <= -Z90;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < NS; g++) begin : g_cordic
			pxy_cordic_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.shift   (SHW'(g)),
				.atan    (atan_step(g)),
				.vld_in  (vld_c[g]),
				.cu_in   (cu_c[g]),
				.cv_in   (cv_c[g]),
				.z_in    (z_c[g]),
				.side_in (sd_c[g]),
				.vld_q   (vld_c[g+1]),
				.cu_q    (cu_c[g+1]),
				.cv_q    (cv_c[g+1]),
				.z_q     (z_c[g+1]),
				.side_q  (sd_c[g+1])
			);
		end
	endgenerate

	// Longitude rounding and clamping, gain partial products.
	logic signed [ZW-1:0]          z_rnd;
	logic signed [ZW-RS-9:0]       z_sh;
	logic signed [LON_W-1:0]       lon_a;
	logic signed [ZW-RS-9:0]       lon180_w;

	assign z_rnd    = z_c[NS] + ZW'(64'sd1 <<< (31 - FRAC_BITS));
	assign z_sh     = z_rnd[ZW-1:32-FRAC_BITS];
	assign lon180_w = (ZW-RS-8)'(LON180);

	always_comb begin
		if (sd_c[NS].x_zero) begin
			lon_a = sd_c[NS].u_neg ? LON180 : '0;
		end else if (!sd_c[NS].x_neg) begin
			if (z_sh < 0) begin
				lon_a = '0;
			end else if (z_sh > lon180_w) begin
				lon_a = LON180;
			end else begin
				lon_a = z_sh[LON_W-1:0];
			end
		end else begin
			if (z_sh > 0) begin
				lon_a = '0;
			end else if (z_sh < -lon180_w) begin
				lon_a = -LON180;
			end else begin
				lon_a = z_sh[LON_W-1:0];
			end
		end
	end

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	dside_t           sd_s1, sd_s2, sd_s3, sd_s4;
	logic [63:0]      pp_lo_s1;
	logic [48:0]      pp_hi_s1;
	logic [MAGW-1:0]  mag_s2;
	logic [NW-1:0]    n_s3;
	logic [PW-1:0]    r0_s4;
	logic [QW-1:0]    nl_s4;
	logic [PW-1:0]    n_hi;

	assign n_hi = PW'(n_s3[NW-1:QW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_c[NS];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.north <= sd_c[NS].north;
			sd_s1.ovf   <= 1'b0;
			sd_s1.lon   <= lon_a;
			pp_lo_s1    <= 64'(cu_c[NS][31:0]) * 64'(INV_GAIN_Q32);
			pp_hi_s1    <= 49'(cu_c[NS][48:32]) * 49'(INV_GAIN_Q32);

			sd_s2  <= sd_s1;
			mag_s2 <= MAGW'(pp_hi_s1) + MAGW'(pp_lo_s1[63:32]);

			sd_s3 <= sd_s2;
			n_s3  <= (NW'(mag_s2) << 8) + (NW'(mag_s2) << 6) + (NW'(mag_s2) << 5)
				+ (NW'(mag_s2) << 3);

			sd_s4.north <= sd_s3.north;
			sd_s4.lon   <= sd_s3.lon;
			sd_s4.ovf   <= (n_hi >= p_eff);
			r0_s4       <= n_hi;
			nl_s4       <= n_s3[QW-1:0];
		end
	end

	logic            vld_d [QW+1];
	logic [PW-1:0]   rem_d [QW+1];
	logic [QW-1:0]   num_d [QW+1];
	logic [QW-1:0]   quo_d [QW+1];
	dside_t          sd_d  [QW+1];

	assign vld_d[0] = vld_s4;
	assign rem_d[0] = r0_s4;
	assign num_d[0] = nl_s4;
	assign quo_d[0] = '0;
	assign sd_d[0]  = sd_s4;

	generate
		for (g = 0; g < QW; g++) begin : g_div
			pxy_div_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.divisor (p_eff),
				.vld_in  (vld_d[g]),
				.rem_in  (rem_d[g]),
				.num_in  (num_d[g]),
				.quo_in  (quo_d[g]),
				.side_in (sd_d[g]),
				.vld_q   (vld_d[g+1]),
				.rem_q   (rem_d[g+1]),
				.num_q   (num_d[g+1]),
				.quo_q   (quo_d[g+1]),
				.side_q  (sd_d[g+1])
			);
		end
	endgenerate

	// Rounding, saturation and hemisphere sign.
	logic [QW:0]          q_rnd;
	logic [25:0]          arc_len;
	logic                 sat;
	logic signed [26:0]   lat_w;
	logic signed [26:0]   lat_n;

	assign q_rnd   = {1'b0, quo_d[QW]} + (QW+1)'(1 << (RS - 1));
	assign arc_len = 26'(q_rnd >> RS);
	assign sat     = sd_d[QW].ovf || (arc_len > DIST180);
	assign lat_w   = sat ? -LAT90 : (LAT90 - $signed({1'b0, arc_len}));
	assign lat_n   = sd_d[QW].north ? lat_w : -lat_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= vld_d[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {7'd0, sd_d[QW].lon, lat_n[LAT_W-1:0]};
			m_axis_tuser <= sat;
		end
	end

endmodule

@@ test/polar_xy_to_lat_lon_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar XY to latitude/longitude testbench
// Streams pixel offsets through the projection under several circumference
// settings, checked against table rows or a local CORDIC and divider model.
// ----------------------------------------------------------------------------
module polar_xy_to_lat_lon_test;

	localparam longint DEG_Q32  = 64'sd246083499208;
	localparam longint INV_GAIN = 64'd2608131497;
	localparam int     NINETY   = 90 << pxy_pkg::FRAC_BITS;
	localparam int     ONE80    = 180 << pxy_pkg::FRAC_BITS;

	typedef struct {
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		logic               sat;
	} fix_t;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic               north;
		bit                 typed;
		fix_t               fix;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tuser;

	logic [31:0] circle_px;
	fix_t        pending_fixes[$];
	bit          quiet;
	int          errors;

	polar_xy_to_lat_lon DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic longint arc_step(input int i);
		longint head[8];
		longint t;
		head = '{64'sd193273528320, 64'sd114096026022, 64'sd60285206654,
			64'sd30601712202, 64'sd15360239180, 64'sd7687607525,
			64'sd3844741810, 64'sd1922488225};
		if (i < 8) begin
			return head[i];
		end
		t = DEG_Q32 >>> i;
		if (3 * i < 64) begin
			t = t - ((DEG_Q32 >>> (3 * i)) / 3);
		end
		return t;
	endfunction

	function automatic fix_t latlon_of(input logic signed [23:0] xs,
		input logic signed [23:0] ys, input logic north, input logic [31:0] ppc);
		longint x, y, u, cu, cv, z, t, su, sv, lat, lon;
		longint unsigned mag, p, q1, rem, arc_len, cuu;
		bit sat;
		fix_t f;
		x = xs;
		y = ys;
		u = north ? -y : y;
		cu = u <<< pxy_pkg::CORDIC_GUARD;
		cv = x <<< pxy_pkg::CORDIC_GUARD;
		z = 0;
		sat = 1'b0;
		if (cu < 0) begin
			if (cv >= 0) begin
				t = cu; cu = cv; cv = -t; z = 64'sd90 <<< 32;
			end else begin
				t = cu; cu = -cv; cv = t; z = -(64'sd90 <<< 32);
			end
		end
		for (int i = 0; i < pxy_pkg::CORDIC_STAGES; i++) begin
			su = cu >>> i;
			sv = cv >>> i;
			if (cv >= 0) begin
				cu = cu + sv; cv = cv - su; z = z + arc_step(i);
			end else begin
				cu = cu - sv; cv = cv + su; z = z - arc_step(i);
			end
		end
		cuu = cu;
		mag = (cuu >> 32) * INV_GAIN + (((cuu & 64'hFFFFFFFF) * INV_GAIN) >> 32);
		p = (ppc == 0) ? 64'd1 : {32'd0, ppc};
		q1 = mag / p;
		rem = mag % p;
		if (q1 > (64'd1 << pxy_pkg::CORDIC_GUARD)) begin
			lat = -NINETY;
			sat = 1'b1;
		end else begin
			arc_len = q1 * 360 + (rem * 360) / p;
			arc_len = (arc_len + 64'd128) >> 8;
			lat = NINETY - longint'(arc_len);
			if (lat < -NINETY) begin
				lat = -NINETY;
				sat = 1'b1;
			end
		end
		if (!north) begin
			lat = -lat;
		end
		if (x == 0) begin
			lon = (u < 0) ? ONE80 : 0;
		end else begin
			lon = (z + (64'sd1 <<< 15)) >>> 16;
			if (x > 0) begin
				if (lon < 0) lon = 0;
				if (lon > ONE80) lon = ONE80;
			end else begin
				if (lon > 0) lon = 0;
				if (lon < -ONE80) lon = -ONE80;
			end
		end
		f.lat = lat[23:0];
		f.lon = lon[24:0];
		f.sat = sat;
		return f;
	endfunction

	task automatic send(input logic signed [23:0] x, input logic signed [23:0] y,
		input logic north, input bit typed, input fix_t fix);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		s_axis_tuser <= north;
		do @(posedge clk); while (!s_axis_tready);
		pending_fixes.push_back(typed ? fix : latlon_of(x, y, north, circle_px));
		@(negedge clk);
	endtask

	task automatic set_circle(input logic [31:0] v);
		s_axis_tvalid <= 1'b0;
		wait (pending_fixes.size() == 0);
		repeat (70) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		circle_px = v;
	endtask

	function automatic logic signed [23:0] pick_coord(input logic [31:0] ppc);
		int unsigned lim;
		logic signed [23:0] c;
		if ($urandom_range(0, 3) == 0) begin
			return 24'($urandom);
		end
		lim = (ppc / 2 > 32'd8388607) ? 32'd8388607 : ppc / 2 + 1;
		c = 24'($urandom_range(0, lim));
		return $urandom_range(0, 1) ? -c : c;
	endfunction

	// Ready side: random stall bursts until the quiet tail of the run.
	initial begin
		int hold;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 17);
				m_axis_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		fix_t want;
		logic signed [23:0] lat;
		logic signed [24:0] lon;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				lat = m_axis_tdata[23:0];
				lon = m_axis_tdata[48:24];
				if (pending_fixes.size() == 0) begin
					$error("unexpected transaction lat=%0d lon=%0d", lat, lon);
					errors++;
				end else begin
					want = pending_fixes.pop_front();
					if (lat !== want.lat) begin
						$error("latitude expected %0d actual %0d", want.lat, lat);
						errors++;
					end
					if (lon !== want.lon) begin
						$error("longitude expected %0d actual %0d", want.lon, lon);
						errors++;
					end
					if (m_axis_tuser !== want.sat) begin
						$error("beyond_range expected %0d actual %0d", want.sat,
							m_axis_tuser);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		row_t table_rows[$];
		row_t r;
		fix_t none;
		logic [31:0] circles[5];
		none = '{0, 0, 0};
		errors = 0;
		quiet = 1'b0;
		circle_px = 32'd1;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// After reset one pixel spans the full circle, so any nonzero offset
		// saturates.
		table_rows = '{
			'{0, 0, 1, 1, '{NINETY, 0, 0}},
			'{0, 0, 0, 1, '{-NINETY, 0, 0}},
			'{0, 5, 1, 1, '{-NINETY, ONE80, 1}},
			'{0, -5, 1, 1, '{-NINETY, 0, 1}},
			'{0, 5, 0, 1, '{NINETY, 0, 1}},
			'{0, -8388608, 1, 1, '{-NINETY, 0, 1}},
			'{0, 8388607, 0, 1, '{NINETY, 0, 1}},
			'{0, 8388607, 1, 1, '{-NINETY, ONE80, 1}},
			'{8388607, 8388607, 1, 0, none},
			'{-8388608, -8388608, 1, 0, none},
			'{-8388608, 0, 0, 0, none},
			'{8388607, -8388608, 0, 0, none},
			'{1, 0, 1, 0, none},
			'{-1, 0, 1, 0, none},
			'{-1, -1, 0, 0, none}
		};
		foreach (table_rows[i]) begin
			r = table_rows[i];
			send(r.x, r.y, r.north, r.typed, r.fix);
		end

		// At 360 pixels per circle one pixel is one degree: the half-circle edge.
		set_circle(32'd360);
		send(0, 180, 1, 0, none);
		send(0, 181, 1, 0, none);
		send(180, 0, 0, 0, none);
		send(-181, 0, 0, 0, none);
		send(-127, -127, 1, 0, none);
		send(127, -127, 0, 0, none);

		circles = '{32'd0, 32'hFFFFFFFF, 32'd1000, 32'd50000, $urandom};
		foreach (circles[c]) begin
			set_circle(circles[c]);
			for (int k = 0; k < 200; k++) begin
				if (c == 2 && k == 100) begin
					s_axis_tvalid <= 1'b0;
					wait (pending_fixes.size() == 0);
					@(negedge clk);
				end
				if (c == 4 && k == 120) begin
					quiet = 1'b1;
				end
				send(pick_coord(circle_px), pick_coord(circle_px),
					$urandom_range(0, 1), 0, none);
			end
		end
		s_axis_tvalid <= 1'b0;

		wait (pending_fixes.size() == 0);
		repeat (80) @(negedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ polar_xy_to_lat_lon.f @@
design/pxy_pkg.sv
design/pxy_cordic_cell.sv
design/pxy_div_cell.sv
design/polar_xy_to_lat_lon.sv
test/polar_xy_to_lat_lon_test.sv
